@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; they expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define TBRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tbrr assertion failed");

// Check that cond never holds at a clock edge outside reset.
`define TBRR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tbrr forbidden condition");

`endif

@@ hw/rtl/tbrr_pkg.sv @@
// Constants, codes and the class function of the tipping bucket rain rate block.
package tbrr_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TIP_W   = 32;
  localparam int unsigned UM_W    = 16;
  localparam int unsigned RAIN_W  = 48;
  localparam int unsigned SCALE_W = 22;
  localparam int unsigned PROD_W  = RAIN_W + SCALE_W;
  localparam int unsigned INT_W   = 32;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CNT_W   = 5;

  // Milliseconds per hour, consumed MSB first by the serial scaler.
  localparam logic [SCALE_W-1:0] MS_PER_HOUR = 22'd3600000;

  localparam logic [INT_W-1:0] THR_VLIGHT = 32'd2500;
  localparam logic [INT_W-1:0] THR_LIGHT  = 32'd10000;
  localparam logic [INT_W-1:0] THR_MOD    = 32'd20000;
  localparam logic [INT_W-1:0] THR_HEAVY  = 32'd50000;
  localparam logic [INT_W-1:0] THR_VHEAVY = 32'd100000;

  localparam logic [1:0] CMD_TIP   = 2'd0;
  localparam logic [1:0] CMD_POLL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_WINDOW   = 2'd1;
  localparam logic [1:0] CFG_UM_TIP   = 2'd2;

  localparam logic [CLASS_W-1:0] CLS_NONE    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_VLIGHT  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_LIGHT   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_MOD     = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_HEAVY   = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_VHEAVY  = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_EXTREME = 3'd6;

  function automatic logic [CLASS_W-1:0] class_of(input logic rain_nz,
                                                  input logic [INT_W-1:0] v);
    logic [CLASS_W-1:0] c;
    if (!rain_nz)             c = CLS_NONE;
    else if (v < THR_VLIGHT)  c = CLS_VLIGHT;
    else if (v < THR_LIGHT)   c = CLS_LIGHT;
    else if (v < THR_MOD)     c = CLS_MOD;
    else if (v < THR_HEAVY)   c = CLS_HEAVY;
    else if (v < THR_VHEAVY)  c = CLS_VHEAVY;
    else                      c = CLS_EXTREME;
    return c;
  endfunction

endpackage

@@ hw/rtl/tipping_bucket_rain_rate_top.sv @@
// Tipping bucket rain gauge: tip debounce, window close, serial intensity unit.
//
// Input channel (in_valid_i/in_ready_o) takes one event word: cmd_i selects a
// bucket tip (now_us_i), a window poll, a total clear or a window restart
// (now_ms_i). Every event yields exactly one result word on the output channel
// (out_valid_o/out_ready_i): the window_closed flag plus the stored tip count,
// intensity, class and total.
// Tip, clear, restart and a poll that closes nothing go from acceptance straight
// to the emit state, which loads the output register once it is free. A poll that
// closes a window runs the intensity unit: a multiply of tips by rainfall per tip,
// shift-and-add for the hour scale (one constant bit per cycle), one overflow
// check, then a restoring divider that retires one quotient bit per cycle; the
// divider is skipped when the window had no rain or the quotient would overflow.
// One event is in work at a time; the next is taken as soon as its result has
// moved into the output register, even while that word waits for the receiver.
// A stalled receiver holds the output word and, once the result path is full,
// holds off the input side. Reset clears all state and loads the default
// configuration (50000 us debounce, 60000 ms window, 200 um per tip).
// Configuration writes via cfg_we_i/cfg_addr_i/cfg_wdata_i take effect at once.
`include "assert_macros.svh"

module tipping_bucket_rain_rate_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [tbrr_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [tbrr_pkg::TIME_W-1:0]   now_us_i,
  input  logic [tbrr_pkg::TIME_W-1:0]   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          window_closed_o,
  output logic [tbrr_pkg::TIP_W-1:0]    window_tips_o,
  output logic [tbrr_pkg::INT_W-1:0]    intensity_umh_o,
  output logic [tbrr_pkg::CLASS_W-1:0]  rain_class_o,
  output logic [tbrr_pkg::RAIN_W-1:0]   total_um_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]                     state_q;
  logic [tbrr_pkg::CNT_W-1:0]     cnt_q;
  logic                           closed_q;

  logic [tbrr_pkg::TIME_W-1:0]    debounce_q;
  logic [tbrr_pkg::TIME_W-1:0]    window_q;
  logic [tbrr_pkg::UM_W-1:0]      um_q;

  logic [tbrr_pkg::TIP_W-1:0]     pend_q;
  logic [tbrr_pkg::TIME_W-1:0]    last_tip_q;
  logic [tbrr_pkg::TIME_W-1:0]    win_start_q;
  logic [tbrr_pkg::TIP_W-1:0]     last_tips_q;
  logic [tbrr_pkg::INT_W-1:0]     last_int_q;
  logic [tbrr_pkg::CLASS_W-1:0]   last_class_q;
  logic [tbrr_pkg::RAIN_W-1:0]    total_q;

  logic [tbrr_pkg::RAIN_W-1:0]    rain_q;
  logic [tbrr_pkg::PROD_W-1:0]    prod_q;
  logic [tbrr_pkg::TIME_W-1:0]    elapsed_q;
  logic [tbrr_pkg::INT_W-1:0]     rem_q;
  logic [tbrr_pkg::INT_W-1:0]     quo_q;
  logic                           sat_q;

  logic                           out_valid_q;
  logic                           out_closed_q;
  logic [tbrr_pkg::TIP_W-1:0]     out_tips_q;
  logic [tbrr_pkg::INT_W-1:0]     out_int_q;
  logic [tbrr_pkg::CLASS_W-1:0]   out_class_q;
  logic [tbrr_pkg::RAIN_W-1:0]    out_total_q;

  logic                           in_fire;
  logic                           out_load;
  logic [tbrr_pkg::TIME_W-1:0]    tip_diff;
  logic                           tip_ok;
  logic [tbrr_pkg::TIME_W-1:0]    poll_elapsed;
  logic                           poll_close;
  logic                           close_now;
  logic [tbrr_pkg::RAIN_W-1:0]    rain_mul;
  logic [tbrr_pkg::PROD_W-1:0]    scale_add;
  logic [tbrr_pkg::PROD_W-tbrr_pkg::INT_W-1:0] prod_hi;
  logic                           sat_hit;
  logic [tbrr_pkg::INT_W:0]       div_trial;
  logic [tbrr_pkg::INT_W:0]       div_diff;
  logic                           div_ge;
  logic [tbrr_pkg::INT_W-1:0]     fin_int;
  logic [tbrr_pkg::CLASS_W-1:0]   fin_class;
  logic [tbrr_pkg::RAIN_W:0]      total_sum;
  logic [tbrr_pkg::RAIN_W-1:0]    total_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign tip_diff     = now_us_i - last_tip_q;
  assign tip_ok       = tip_diff > debounce_q;
  assign poll_elapsed = now_ms_i - win_start_q;
  assign poll_close   = poll_elapsed >= window_q;
  assign close_now    = (cmd_i == tbrr_pkg::CMD_POLL) && poll_close;

  assign rain_mul  = {{(tbrr_pkg::RAIN_W-tbrr_pkg::TIP_W){1'b0}}, last_tips_q} *
                     {{(tbrr_pkg::RAIN_W-tbrr_pkg::UM_W){1'b0}}, um_q};
  assign scale_add = tbrr_pkg::MS_PER_HOUR[cnt_q] ?
                     {{tbrr_pkg::SCALE_W{1'b0}}, rain_q} : '0;

  // Quotient fits 32 bits only when the upper dividend part is below the divisor.
  assign prod_hi = prod_q[tbrr_pkg::PROD_W-1:tbrr_pkg::INT_W];
  assign sat_hit = prod_hi >=
                   {{(tbrr_pkg::PROD_W-tbrr_pkg::INT_W-tbrr_pkg::TIME_W){1'b0}}, elapsed_q};

  assign div_trial = {rem_q, quo_q[tbrr_pkg::INT_W-1]};
  assign div_ge    = div_trial >= {1'b0, elapsed_q};
  assign div_diff  = div_trial - {1'b0, elapsed_q};

  assign fin_int   = sat_q ? '1 : quo_q;
  assign fin_class = tbrr_pkg::class_of(rain_q != '0, fin_int);
  assign total_sum  = {1'b0, total_q} + {1'b0, rain_q};
  assign total_next = total_sum[tbrr_pkg::RAIN_W] ? '1 : total_sum[tbrr_pkg::RAIN_W-1:0];

  // Control, configuration and event state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      closed_q     <= 1'b0;
      debounce_q   <= 32'd50000;
      window_q     <= 32'd60000;
      um_q         <= 16'd200;
      pend_q       <= '0;
      last_tip_q   <= '0;
      win_start_q  <= '0;
      last_tips_q  <= '0;
      last_int_q   <= '0;
      last_class_q <= tbrr_pkg::CLS_NONE;
      total_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          tbrr_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
          tbrr_pkg::CFG_WINDOW:   window_q   <= cfg_wdata_i;
          tbrr_pkg::CFG_UM_TIP:   um_q       <= cfg_wdata_i[tbrr_pkg::UM_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            closed_q <= close_now;
            state_q  <= close_now ? ST_MUL : ST_EMIT;
            case (cmd_i)
              tbrr_pkg::CMD_TIP: begin
                if (tip_ok) begin
                  if (pend_q != '1) pend_q <= pend_q + 1'b1;
                  last_tip_q <= now_us_i;
                end
              end
              tbrr_pkg::CMD_POLL: begin
                if (poll_close) begin
                  last_tips_q <= pend_q;
                  pend_q      <= '0;
                  win_start_q <= now_ms_i;
                end
              end
              tbrr_pkg::CMD_CLEAR: total_q <= '0;
              tbrr_pkg::CMD_START: win_start_q <= now_ms_i;
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          cnt_q   <= tbrr_pkg::CNT_W'(tbrr_pkg::SCALE_W - 1);
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (cnt_q == '0) state_q <= ST_CHK;
          else cnt_q <= cnt_q - 1'b1;
        end
        ST_CHK: begin
          cnt_q <= tbrr_pkg::CNT_W'(tbrr_pkg::INT_W - 1);
          if (rain_q == '0 || sat_hit) state_q <= ST_FIN;
          else state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == '0) state_q <= ST_FIN;
          else cnt_q <= cnt_q - 1'b1;
        end
        ST_FIN: begin
          last_int_q   <= fin_int;
          last_class_q <= fin_class;
          total_q      <= total_next;
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Intensity datapath: serial hour scale, then one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) elapsed_q <= poll_elapsed;
      end
      ST_MUL: begin
        rain_q <= rain_mul;
        prod_q <= '0;
      end
      ST_SCALE: begin
        prod_q <= {prod_q[tbrr_pkg::PROD_W-2:0], 1'b0} + scale_add;
      end
      ST_CHK: begin
        if (rain_q == '0) begin
          sat_q <= 1'b0;
          quo_q <= '0;
        end else if (sat_hit) begin
          sat_q <= 1'b1;
        end else begin
          sat_q <= 1'b0;
          rem_q <= prod_hi[tbrr_pkg::INT_W-1:0];
          quo_q <= prod_q[tbrr_pkg::INT_W-1:0];
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? div_diff[tbrr_pkg::INT_W-1:0] : div_trial[tbrr_pkg::INT_W-1:0];
        quo_q <= {quo_q[tbrr_pkg::INT_W-2:0], div_ge};
      end
      default: ;
    endcase
  end

  // Output register: hold the word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_closed_q <= closed_q;
      out_tips_q   <= last_tips_q;
      out_int_q    <= last_int_q;
      out_class_q  <= last_class_q;
      out_total_q  <= total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_closed_o = out_closed_q;
  assign window_tips_o   = out_tips_q;
  assign intensity_umh_o = out_int_q;
  assign rain_class_o    = out_class_q;
  assign total_um_o      = out_total_q;

  `TBRR_ASSERT(a_div_rem_below_divisor, (state_q == ST_DIV) |-> (rem_q < elapsed_q))
  `TBRR_ASSERT(a_fin_only_on_close, (state_q == ST_FIN) |-> closed_q)
  `TBRR_ASSERT(a_no_rain_no_intensity,
               (out_valid_o && rain_class_o == tbrr_pkg::CLS_NONE) |-> (intensity_umh_o == '0))
  `TBRR_ASSERT_NEVER(a_no_accept_in_work, in_fire && (state_q != ST_IDLE))

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the tipping bucket rain rate block: directed events, then random.
module testbench;
  import tbrr_pkg::*;

  localparam logic [79:0] HOUR_MS = 80'd3600000;
  localparam logic [47:0] RAIN_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] UMH_MAX = 32'hFFFF_FFFF;
  localparam int unsigned GAP_MAX = 17;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_WORDS = 125;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic        closed;
    logic [31:0] tips;
    logic [31:0] umh;
    logic [2:0]  cls;
    logic [47:0] total;
  } reading_t;

  // sel holds the command of an event row or the register index of a write row;
  // a write row carries its value in us.
  typedef struct packed {
    logic        is_reg;
    logic [1:0]  sel;
    logic [31:0] us;
    logic [31:0] ms;
    logic        typed;
    reading_t    want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [31:0] now_us;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_ready;
  logic        window_closed;
  logic [31:0] window_tips;
  logic [31:0] intensity_umh;
  logic [2:0]  rain_class;
  logic [47:0] total_um;

  // Gauge predictor state and configuration.
  logic [31:0] cfg_debounce = 32'd50000;
  logic [31:0] cfg_window = 32'd60000;
  logic [15:0] cfg_um = 16'd200;
  logic [31:0] tips_pending = '0;
  logic [31:0] last_tip_us = '0;
  logic [31:0] win_start_ms = '0;
  logic [31:0] held_tips = '0;
  logic [31:0] held_umh = '0;
  logic [2:0]  held_class = CLS_NONE;
  logic [47:0] rain_total = '0;

  reading_t    readings_due[$];
  plan_row_t   plan[$];
  int unsigned fault_count = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  tipping_bucket_rain_rate_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .now_us_i       (now_us),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .window_closed_o(window_closed),
    .window_tips_o  (window_tips),
    .intensity_umh_o(intensity_umh),
    .rain_class_o   (rain_class),
    .total_um_o     (total_um)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 3000000);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [31:0] rate_umh(logic [47:0] rain, logic [31:0] elapsed);
    logic [79:0] quo;
    if (rain == '0) return '0;
    if (elapsed == '0) return UMH_MAX;
    quo = ({32'd0, rain} * HOUR_MS) / {48'd0, elapsed};
    return (quo > {48'd0, UMH_MAX}) ? UMH_MAX : quo[31:0];
  endfunction

  function automatic logic [2:0] rate_class(logic [47:0] rain, logic [31:0] umh);
    if (rain == '0) return CLS_NONE;
    if (umh < 32'd2500) return CLS_VLIGHT;
    if (umh < 32'd10000) return CLS_LIGHT;
    if (umh < 32'd20000) return CLS_MOD;
    if (umh < 32'd50000) return CLS_HEAVY;
    if (umh < 32'd100000) return CLS_VHEAVY;
    return CLS_EXTREME;
  endfunction

  // Apply one event to the gauge state and return the reading it reports.
  function automatic reading_t advance_gauge(logic [1:0] op, logic [31:0] us, logic [31:0] ms);
    reading_t    r;
    logic [31:0] since_tip;
    logic [31:0] elapsed;
    logic [47:0] rain;
    r.closed = 1'b0;
    case (op)
      CMD_TIP: begin
        since_tip = us - last_tip_us;
        if (since_tip > cfg_debounce) begin
          if (tips_pending != 32'hFFFF_FFFF) tips_pending = tips_pending + 1;
          last_tip_us = us;
        end
      end
      CMD_POLL: begin
        elapsed = ms - win_start_ms;
        if (elapsed >= cfg_window) begin
          rain = {16'd0, tips_pending} * {32'd0, cfg_um};
          held_tips = tips_pending;
          tips_pending = '0;
          held_umh = rate_umh(rain, elapsed);
          held_class = rate_class(rain, held_umh);
          if (rain > RAIN_MAX - rain_total) rain_total = RAIN_MAX;
          else rain_total = rain_total + rain;
          win_start_ms = ms;
          r.closed = 1'b1;
        end
      end
      CMD_CLEAR: rain_total = '0;
      default: win_start_ms = ms;
    endcase
    r.tips = held_tips;
    r.umh = held_umh;
    r.cls = held_class;
    r.total = rain_total;
    return r;
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(GAP_MAX));
  endfunction

  function automatic plan_row_t ev(logic [1:0] op, logic [31:0] us, logic [31:0] ms,
                                   logic typed = 1'b0, reading_t want = '0);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.sel = op;
    row.us = us;
    row.ms = ms;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t rg(logic [1:0] sel, logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.sel = sel;
    row.us = val;
    return row;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Hold off the sender until every outstanding word has come back.
  task automatic settle();
    in_valid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] sel, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_addr = sel;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (sel)
      CFG_DEBOUNCE: cfg_debounce = val;
      CFG_WINDOW: cfg_window = val;
      default: cfg_um = val[15:0];
    endcase
  endtask

  task automatic send_word(logic [1:0] op, logic [31:0] us, logic [31:0] ms,
                           logic typed = 1'b0, reading_t want = '0);
    reading_t due;
    int       gap;
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    now_us = us;
    now_ms = ms;
    do @(posedge clk); while (!in_ready);
    due = advance_gauge(op, us, ms);
    readings_due.push_back(typed ? want : due);
    @(negedge clk);
  endtask

  // Receiver: stall at random, compare each word with the oldest expectation.
  initial begin
    reading_t want;
    int       stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(out_calm);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (readings_due.size() == 0) begin
        fault_count++;
        $display("%0t unexpected word: expected none, got closed %0b tips %0h", $time,
                 window_closed, window_tips);
      end else begin
        want = readings_due.pop_front();
        check_field("window_closed", 64'(want.closed), 64'(window_closed));
        check_field("window_tips", 64'(want.tips), 64'(window_tips));
        check_field("intensity_umh", 64'(want.umh), 64'(intensity_umh));
        check_field("rain_class", 64'(want.cls), 64'(rain_class));
        check_field("total_um", 64'(want.total), 64'(total_um));
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] us;
    logic [31:0] ms;
    logic [31:0] cur_us;
    logic [31:0] cur_ms;
    logic [31:0] val;
    logic [31:0] us_span;
    logic [31:0] ms_span;
    int unsigned pick;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DEBOUNCE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    cmd = CMD_TIP;
    now_us = '0;
    now_ms = '0;

    // Default setup: debounce edge, timestamp wrap, window edge.
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd0, 1'b1, reading_t'{1'b0, 32'd0, 32'd0, CLS_NONE, 48'd0}));
    plan.push_back(ev(CMD_TIP, 32'd0, 32'd0, 1'b1, reading_t'{1'b0, 32'd0, 32'd0, CLS_NONE, 48'd0}));
    plan.push_back(ev(CMD_TIP, 32'd50000, 32'd0, 1'b1,
                      reading_t'{1'b0, 32'd0, 32'd0, CLS_NONE, 48'd0}));
    plan.push_back(ev(CMD_TIP, 32'd50001, 32'hFFFF_FFFF));
    plan.push_back(ev(CMD_TIP, 32'hFFFF_FFFF, 32'd0));
    plan.push_back(ev(CMD_TIP, 32'd50000, 32'd0));
    plan.push_back(ev(CMD_POLL, 32'hFFFF_FFFF, 32'd59999, 1'b1,
                      reading_t'{1'b0, 32'd0, 32'd0, CLS_NONE, 48'd0}));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd60000, 1'b1,
                      reading_t'{1'b1, 32'd3, 32'd36000, CLS_HEAVY, 48'd600}));
    plan.push_back(ev(CMD_START, 32'd0, 32'hFFFF_FFFF));
    plan.push_back(ev(CMD_TIP, 32'h8000_0000, 32'd0));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd59998, 1'b1,
                      reading_t'{1'b0, 32'd3, 32'd36000, CLS_HEAVY, 48'd600}));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd59999));
    plan.push_back(ev(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                      reading_t'{1'b0, 32'd1, 32'd12000, CLS_MOD, 48'd0}));
    // Zero debounce and zero window, largest rainfall per tip.
    plan.push_back(rg(CFG_DEBOUNCE, 32'd0));
    plan.push_back(rg(CFG_WINDOW, 32'd0));
    plan.push_back(rg(CFG_UM_TIP, 32'd65535));
    plan.push_back(ev(CMD_TIP, 32'h8000_0000, 32'd0));
    plan.push_back(ev(CMD_TIP, 32'h8000_0001, 32'd0));
    plan.push_back(ev(CMD_TIP, 32'h8000_0001, 32'd0));
    plan.push_back(ev(CMD_TIP, 32'h8000_0002, 32'd0));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd59999, 1'b1,
                      reading_t'{1'b1, 32'd2, UMH_MAX, CLS_EXTREME, 48'd131070}));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd59999, 1'b1,
                      reading_t'{1'b1, 32'd0, 32'd0, CLS_NONE, 48'd131070}));
    // Zero rainfall per tip, longest window.
    plan.push_back(rg(CFG_WINDOW, 32'hFFFF_FFFF));
    plan.push_back(rg(CFG_UM_TIP, 32'hFFFF_0000));
    plan.push_back(ev(CMD_TIP, 32'd0, 32'd0));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd59998, 1'b1,
                      reading_t'{1'b1, 32'd1, 32'd0, CLS_NONE, 48'd131070}));
    // Longest debounce, then the shortest nonzero settings.
    plan.push_back(rg(CFG_DEBOUNCE, 32'hFFFF_FFFF));
    plan.push_back(rg(CFG_WINDOW, 32'd1));
    plan.push_back(rg(CFG_UM_TIP, 32'd1));
    plan.push_back(ev(CMD_TIP, 32'd5, 32'd0));
    plan.push_back(ev(CMD_START, 32'd0, 32'd100));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd100, 1'b1,
                      reading_t'{1'b0, 32'd1, 32'd0, CLS_NONE, 48'd131070}));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd101));
    plan.push_back(rg(CFG_DEBOUNCE, 32'd1));
    plan.push_back(ev(CMD_TIP, 32'd6, 32'd0));
    plan.push_back(ev(CMD_TIP, 32'd7, 32'd0));
    plan.push_back(ev(CMD_POLL, 32'd0, 32'd102));

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].sel, plan[i].us);
      end else begin
        send_word(plan[i].sel, plan[i].us, plan[i].ms, plan[i].typed, plan[i].want);
      end
    end

    cur_us = $urandom;
    cur_ms = $urandom;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(5))
        0: val = 32'd0;
        1: val = 32'd1;
        2: val = $urandom_range(2000, 2);
        3: val = 32'd50000;
        4: val = $urandom;
        default: val = 32'hFFFF_FFFF;
      endcase
      write_reg(CFG_DEBOUNCE, val);
      case ($urandom_range(5))
        0: val = 32'd0;
        1: val = 32'd1;
        2: val = $urandom_range(300, 2);
        3: val = $urandom_range(90000, 301);
        4: val = $urandom;
        default: val = 32'hFFFF_FFFF;
      endcase
      write_reg(CFG_WINDOW, val);
      case ($urandom_range(4))
        0: val = 32'd0;
        1: val = 32'd1;
        2: val = $urandom_range(500, 2);
        3: val = 32'd65535;
        default: val = $urandom_range(65535);
      endcase
      // Upper half of the write data is not part of the register.
      write_reg(CFG_UM_TIP, {16'($urandom), val[15:0]});

      us_span = (cfg_debounce <= 32'h00FF_FFFF) ? cfg_debounce + cfg_debounce / 2 + 3
                                                : 32'hFFFF_FFFF;
      ms_span = (cfg_window <= 32'h00FF_FFFF) ? cfg_window / 3 + 2 : 32'hFFFF_FFFF;

      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < 12) begin
          op = 2'($urandom_range(3));
          us = $urandom;
          ms = $urandom;
        end else begin
          pick = $urandom_range(99);
          if (pick < 55) op = CMD_TIP;
          else if (pick < 85) op = CMD_POLL;
          else if (pick < 89) op = CMD_CLEAR;
          else op = CMD_START;
          if (op == CMD_TIP) begin
            cur_us = cur_us + $urandom_range(us_span);
            us = cur_us;
            ms = $urandom;
          end else begin
            cur_ms = cur_ms + $urandom_range(ms_span);
            ms = cur_ms;
            us = $urandom;
          end
        end
        send_word(op, us, ms);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
